// ===== rtl/core/rfrt_pkg.sv =====
// ----------------------------------------------------------------------------
// rfrt_pkg
// Types, codes and defaults shared by the remote frame transmitter modules.
// ----------------------------------------------------------------------------
package rfrt_pkg;

    localparam int DEF_CODE_BITS = 32;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int IN_CODE_W = 32;
    localparam int REP_W     = 8;
    localparam int PHASE_W   = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_TIME      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_TIME  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] RST_TICK_TIME      = 16'd1140;
    localparam logic [CFG_W-1:0] RST_SEPARATOR_TIME = 16'd5472;
    localparam logic [CFG_W-1:0] RST_PREAMBLE_TIME  = 16'd57000;

    // Item kinds.
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    // Frame phases.
    localparam logic [PHASE_W-1:0] PH_IDLE = 4'd0;
    localparam logic [PHASE_W-1:0] PH_PRE  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_GAP  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_LSEP = 4'd3;
    localparam logic [PHASE_W-1:0] PH_RL0  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_RL1  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_BITS = 4'd6;
    localparam logic [PHASE_W-1:0] PH_RSEP = 4'd7;
    localparam logic [PHASE_W-1:0] PH_CL0  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_CL1  = 4'd9;

    typedef struct packed {
        logic [CFG_W-1:0] tick_time;
        logic [CFG_W-1:0] separator_time;
        logic [CFG_W-1:0] preamble_time;
    } t_cfg;

    typedef struct packed {
        logic                 kind;
        logic [IN_CODE_W-1:0] code;
        logic [REP_W-1:0]     repeat_count;
    } t_item;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic done_res;
    } t_result;

    typedef struct packed {
        logic               active;
        logic [PHASE_W-1:0] phase;
        logic [CFG_W-1:0]   time_left;
    } t_seq_status;

endpackage

// ===== rtl/core/rfrt_in_if.sv =====
// ----------------------------------------------------------------------------
// rfrt_in_if
// Input channel: tick and start items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rfrt_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] code;
    logic [7:0]  repeat_count;

    modport source (output valid, output kind, output code, output repeat_count,
                    input ready);
    modport sink   (input valid, input kind, input code, input repeat_count,
                    output ready);
endinterface

// ===== rtl/core/rfrt_out_if.sv =====
// ----------------------------------------------------------------------------
// rfrt_out_if
// Output channel: one result item per input item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rfrt_out_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic busy_res;
    logic done_res;

    modport source (output valid, output pin_level, output busy_res,
                    output done_res, input ready);
    modport sink   (input valid, input pin_level, input busy_res,
                    input done_res, output ready);
endinterface

// ===== rtl/core/rf_remote_frame_transmitter_top.sv =====
// ----------------------------------------------------------------------------
// rf_remote_frame_transmitter_top
// On-off-keyed remote frame transmitter: drives the data pin of an RF module.
// ----------------------------------------------------------------------------
// Usage: each item on the input channel is either a tick, standing for one
// microsecond, or a start request carrying a code word and a repeat count.
// A start while a frame is in progress is ignored. For every accepted item
// exactly one result item leaves on the output channel, giving the pin level
// in force after that item, whether a frame is in progress, and a done flag
// on the tick that ends the frame. The pin carries the inverse of the
// logical frame level and rests low when idle.
// Results are registered in the output buffer. Throughput is one item per
// cycle while the skid register has room; the sequencer state update is a
// single decrement, compare and phase select between registers. The output
// side has a result register plus a skid register, so one further item is
// taken while a result waits; ready falls only with both full. Write
// durations through the configuration port only while the block is idle;
// the block does not enforce this. Synchronous reset loads the default
// durations, returns the sequencer to idle and empties both result registers.
// ----------------------------------------------------------------------------
module rf_remote_frame_transmitter_top #(
    parameter int CODE_BITS = rfrt_pkg::DEF_CODE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rfrt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rfrt_pkg::CFG_W-1:0]     i_cfg_data,
    rfrt_in_if.sink                        i_in,
    rfrt_out_if.source                     o_out
);
    import rfrt_pkg::*;

    t_cfg        cfg;
    t_item       item;
    t_result     seq_result, out_result;
    t_seq_status status;
    logic        can_push, accept;

    assign item.kind         = i_in.kind;
    assign item.code         = i_in.code;
    assign item.repeat_count = i_in.repeat_count;

    // An item is taken whenever the skid register has room.
    assign i_in.ready = can_push;
    assign accept     = i_in.valid & can_push;

    rfrt_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rfrt_seq #(
        .CODE_BITS (CODE_BITS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .i_item   (item),
        .o_result (seq_result),
        .o_status (status)
    );

    rfrt_out_buf u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_result   (seq_result),
        .o_can_push (can_push),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_result   (out_result)
    );

    assign o_out.pin_level = out_result.pin_level;
    assign o_out.busy_res  = out_result.busy_res;
    assign o_out.done_res  = out_result.done_res;

    // The sequencer is idle exactly when its phase is idle.
    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.active == (status.phase != PH_IDLE))
        else $error("active flag and phase disagree");

    // A tick inside a segment that is not ending counts the segment down.
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && item.kind == KIND_TICK && status.active && status.time_left > 16'd1)
        |=> status.time_left == $past(status.time_left) - 16'd1)
        else $error("segment timer did not count down");

    // The end of a frame leaves the sequencer idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && seq_result.done_res) |=> !status.active)
        else $error("sequencer still active after frame end");

endmodule

// ===== rtl/core/rfrt_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rfrt_cfg_regs
// Configuration registers for the segment durations.
// ----------------------------------------------------------------------------
module rfrt_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rfrt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rfrt_pkg::CFG_W-1:0]     i_cfg_data,
    output rfrt_pkg::t_cfg                 o_cfg
);
    import rfrt_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_time      <= RST_TICK_TIME;
            r_cfg.separator_time <= RST_SEPARATOR_TIME;
            r_cfg.preamble_time  <= RST_PREAMBLE_TIME;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TICK_TIME:      r_cfg.tick_time      <= i_cfg_data;
                CFG_SEPARATOR_TIME: r_cfg.separator_time <= i_cfg_data;
                CFG_PREAMBLE_TIME:  r_cfg.preamble_time  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/rfrt_seq.sv =====
// ----------------------------------------------------------------------------
// rfrt_seq
// Frame sequencer: holds the frame state and advances it by one item.
// ----------------------------------------------------------------------------
module rfrt_seq #(
    parameter int CODE_BITS = rfrt_pkg::DEF_CODE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rfrt_pkg::t_cfg        i_cfg,
    input  logic                  i_accept,
    input  rfrt_pkg::t_item       i_item,
    output rfrt_pkg::t_result     o_result,
    output rfrt_pkg::t_seq_status o_status
);
    import rfrt_pkg::*;

    localparam int HBI_W = (CODE_BITS > 1) ? $clog2(2 * CODE_BITS) : 1;
    localparam logic [HBI_W-1:0] LAST_HALF = HBI_W'(2 * CODE_BITS - 1);

    logic                 r_active,    n_active;
    logic [PHASE_W-1:0]   r_phase,     n_phase;
    logic [HBI_W-1:0]     r_hbi,       n_hbi;
    logic [REP_W-1:0]     r_repeats,   n_repeats;
    logic [CFG_W-1:0]     r_time_left, n_time_left;
    logic [CODE_BITS-1:0] r_code,      n_code;

    logic [CFG_W-1:0] tick_d, sep_d, pre_d, time_dec;
    logic             level, done;

    // A duration of zero counts as one tick.
    assign tick_d   = (i_cfg.tick_time == '0) ? CFG_W'(1) : i_cfg.tick_time;
    assign sep_d    = (i_cfg.separator_time == '0) ? CFG_W'(1) : i_cfg.separator_time;
    assign pre_d    = (i_cfg.preamble_time == '0) ? CFG_W'(1) : i_cfg.preamble_time;
    assign time_dec = r_time_left - CFG_W'(1);

    always_comb begin
        n_active    = r_active;
        n_phase     = r_phase;
        n_hbi       = r_hbi;
        n_repeats   = r_repeats;
        n_time_left = r_time_left;
        n_code      = r_code;
        done        = 1'b0;

        if (i_item.kind == KIND_START) begin
            if (!r_active) begin
                n_active    = 1'b1;
                n_code      = CODE_BITS'(i_item.code);
                n_repeats   = i_item.repeat_count;
                n_hbi       = '0;
                n_phase     = PH_PRE;
                n_time_left = pre_d;
            end
        end else if (r_active) begin
            n_time_left = time_dec;
            if (time_dec == '0) begin
                n_time_left = tick_d;
                unique case (r_phase)
                    PH_PRE:  n_phase = PH_GAP;
                    PH_GAP: begin
                        n_phase     = PH_LSEP;
                        n_time_left = sep_d;
                    end
                    PH_LSEP: n_phase = (r_repeats != '0) ? PH_RL0 : PH_CL0;
                    PH_RL0:  n_phase = PH_RL1;
                    PH_RL1: begin
                        n_hbi   = '0;
                        n_phase = PH_BITS;
                    end
                    PH_BITS: begin
                        // The code word rotates once per bit, so after a
                        // whole word it is back in place for the next repeat.
                        if (r_hbi[0]) begin
                            n_code = (r_code << 1) | (r_code >> (CODE_BITS - 1));
                        end
                        if (r_hbi != LAST_HALF) begin
                            n_hbi = r_hbi + HBI_W'(1);
                        end else begin
                            n_phase     = PH_RSEP;
                            n_time_left = sep_d;
                        end
                    end
                    PH_RSEP: begin
                        n_repeats = r_repeats - REP_W'(1);
                        n_phase   = (n_repeats != '0) ? PH_RL0 : PH_CL0;
                    end
                    PH_CL0:  n_phase = PH_CL1;
                    default: begin
                        n_active    = 1'b0;
                        n_phase     = PH_IDLE;
                        n_time_left = '0;
                        n_hbi       = '0;
                        done        = 1'b1;
                    end
                endcase
            end
        end
    end

    always_comb begin
        case (n_phase) inside
            PH_GAP, PH_RL0, PH_CL0: level = 1'b0;
            PH_BITS:                level = n_code[CODE_BITS-1] ^ n_hbi[0];
            default:                level = 1'b1;
        endcase
    end

    assign o_result.pin_level = n_active & ~level;
    assign o_result.busy_res  = n_active;
    assign o_result.done_res  = done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_phase     <= PH_IDLE;
            r_hbi       <= '0;
            r_repeats   <= '0;
            r_time_left <= '0;
            r_code      <= '0;
        end else if (i_accept) begin
            r_active    <= n_active;
            r_phase     <= n_phase;
            r_hbi       <= n_hbi;
            r_repeats   <= n_repeats;
            r_time_left <= n_time_left;
            r_code      <= n_code;
        end
    end

    assign o_status.active    = r_active;
    assign o_status.phase     = r_phase;
    assign o_status.time_left = r_time_left;

endmodule

// ===== rtl/core/rfrt_out_buf.sv =====
// ----------------------------------------------------------------------------
// rfrt_out_buf
// Result register with a skid stage, so input is taken while output stalls.
// ----------------------------------------------------------------------------
module rfrt_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rfrt_pkg::t_result i_result,
    output logic              o_can_push,
    output logic              o_valid,
    input  logic              i_ready,
    output rfrt_pkg::t_result o_result
);
    import rfrt_pkg::*;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    pop;

    assign pop        = r_out_valid & i_ready;
    assign o_can_push = ~r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (pop) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (i_push) begin
                if (!r_out_valid || pop) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== test/rf_remote_frame_transmitter_top_test.sv =====
// ----------------------------------------------------------------------------
// rf_remote_frame_transmitter_top_test
// Self-checking testbench for the on-off-keyed remote frame transmitter.
// A queue of tick and start items feeds a falling-edge driver. A rising-edge
// monitor runs every accepted item through a frame sequencer model kept in
// this file, and checks each result item against the oldest prediction. The
// run covers a directed opening, then random frames under three idling
// patterns and several duration settings, zero durations among them.
// ----------------------------------------------------------------------------
module rf_remote_frame_transmitter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rfrt_pkg::*;

    localparam int HALF_PERIOD = 6;
    // Cycles with no item moving on either channel before the run is abandoned.
    // The longest quiet spell in a correct run is a few register writes and the
    // settling pause, or an unlucky run of random stalls.
    localparam int STALL_LIMIT = 1000;
    localparam int HALF_BITS   = 2 * DEF_CODE_BITS;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    rfrt_in_if  in_ch ();
    rfrt_out_if out_ch ();

    rf_remote_frame_transmitter_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Frame sequencer model. It holds its own copy of the durations, which are
    // updated whenever a register is written, and its own frame state.
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0]     tick_len = RST_TICK_TIME;
    logic [CFG_W-1:0]     sep_len  = RST_SEPARATOR_TIME;
    logic [CFG_W-1:0]     pre_len  = RST_PREAMBLE_TIME;

    logic                 fr_active = 1'b0;
    logic [PHASE_W-1:0]   fr_phase  = PH_IDLE;
    logic [6:0]           fr_half   = '0;
    logic [REP_W-1:0]     fr_reps   = '0;
    logic [CFG_W-1:0]     fr_left   = '0;
    logic [IN_CODE_W-1:0] fr_code   = '0;

    // Items waiting to be driven, and the result items still to arrive.
    t_item   pending_items[$];
    t_result expected_pins[$];

    logic item_on_bus   = 1'b0;
    int   send_gap_pct  = 0;
    int   recv_gap_pct  = 0;
    int   fault_count   = 0;
    int   quiet_cycles  = 0;

    // A duration register holding zero behaves as a single tick.
    function automatic logic [CFG_W-1:0] span(input logic [CFG_W-1:0] d);
        return (d == '0) ? CFG_W'(1) : d;
    endfunction

    function automatic void enter_segment(input logic [PHASE_W-1:0] ph);
        fr_phase = ph;
        if (ph == PH_PRE)
            fr_left = span(pre_len);
        else if (ph == PH_LSEP || ph == PH_RSEP)
            fr_left = span(sep_len);
        else
            fr_left = span(tick_len);
    endfunction

    // Logical level of the current segment; the bit cells send b then not-b.
    function automatic logic frame_level();
        int   pos;
        logic b;
        case (fr_phase) inside
            PH_GAP, PH_RL0, PH_CL0: return 1'b0;
            PH_BITS: begin
                pos = DEF_CODE_BITS - 1 - int'(fr_half >> 1);
                b   = fr_code[pos];
                return fr_half[0] ? ~b : b;
            end
            default: return 1'b1;
        endcase
    endfunction

    // Moves on to the next segment; returns high when the frame has ended.
    function automatic logic close_segment();
        case (fr_phase)
            PH_PRE:  enter_segment(PH_GAP);
            PH_GAP:  enter_segment(PH_LSEP);
            PH_LSEP: enter_segment((fr_reps != '0) ? PH_RL0 : PH_CL0);
            PH_RL0:  enter_segment(PH_RL1);
            PH_RL1: begin
                fr_half = '0;
                enter_segment(PH_BITS);
            end
            PH_BITS: begin
                if (int'(fr_half) + 1 < HALF_BITS) begin
                    fr_half = fr_half + 7'd1;
                    enter_segment(PH_BITS);
                end else begin
                    enter_segment(PH_RSEP);
                end
            end
            PH_RSEP: begin
                fr_reps = fr_reps - REP_W'(1);
                enter_segment((fr_reps != '0) ? PH_RL0 : PH_CL0);
            end
            PH_CL0:  enter_segment(PH_CL1);
            default: begin
                fr_active = 1'b0;
                fr_phase  = PH_IDLE;
                fr_left   = '0;
                fr_half   = '0;
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // Applies one accepted item to the model and gives the result it causes.
    function automatic t_result advance_frame(input t_item it);
        t_result r;
        logic    ended;
        ended = 1'b0;
        if (it.kind == KIND_START) begin
            // A start while a frame runs leaves everything as it is.
            if (!fr_active) begin
                fr_active = 1'b1;
                fr_code   = it.code;
                fr_reps   = it.repeat_count;
                fr_half   = '0;
                enter_segment(PH_PRE);
            end
        end else if (fr_active) begin
            fr_left = fr_left - CFG_W'(1);
            if (fr_left == '0)
                ended = close_segment();
        end
        r.pin_level = fr_active ? ~frame_level() : 1'b0;
        r.busy_res  = fr_active;
        r.done_res  = ended;
        return r;
    endfunction

    // Number of tick items a whole frame takes under the current durations.
    function automatic int frame_ticks(input int reps);
        int t;
        int s;
        t = int'(span(tick_len));
        s = int'(span(sep_len));
        return int'(span(pre_len)) + t + s + reps * ((HALF_BITS + 2) * t + s) + 2 * t;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic queue_start(input logic [IN_CODE_W-1:0] code, input logic [REP_W-1:0] reps);
        t_item it;
        it.kind         = KIND_START;
        it.code         = code;
        it.repeat_count = reps;
        pending_items.push_back(it);
    endtask

    // Ticks carry random code and count fields, which the block must ignore.
    task automatic queue_ticks(input int n);
        t_item it;
        for (int i = 0; i < n; i++) begin
            it.kind         = KIND_TICK;
            it.code         = $urandom();
            it.repeat_count = REP_W'($urandom_range(255));
            pending_items.push_back(it);
        end
    endtask

    // Holds the sender back until every item has gone and every result is in.
    task automatic wait_drained();
        while (pending_items.size() != 0 || item_on_bus || expected_pins.size() != 0)
            @(posedge i_clk);
    endtask

    // Runs any frame left open to its end, then lets the block settle so that
    // the durations may be changed safely.
    task automatic close_phase();
        wait_drained();
        while (fr_active) begin
            queue_ticks(32);
            wait_drained();
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_TICK_TIME:      tick_len = val;
            CFG_SEPARATOR_TIME: sep_len  = val;
            CFG_PREAMBLE_TIME:  pre_len  = val;
            default: ;
        endcase
    endtask

    task automatic set_durations(input logic [CFG_W-1:0] tick, input logic [CFG_W-1:0] sep,
                                 input logic [CFG_W-1:0] pre);
        write_reg(CFG_TICK_TIME, tick);
        write_reg(CFG_SEPARATOR_TIME, sep);
        write_reg(CFG_PREAMBLE_TIME, pre);
    endtask

    // Random traffic. Most of it is whole frames with random code words, now
    // and then with a start item dropped into the middle of the frame, which
    // the block must ignore. The rest is frames cut short, whose remainder
    // is then run off by the items that follow, and short runs of ticks that
    // usually fall on an idle block. Now and then the sender holds back until
    // every result is in.
    task automatic random_frames(input int target);
        int counted;
        int pick;
        int reps;
        int len;
        int cut;
        counted = 0;
        while (counted < target) begin
            pick = $urandom_range(99);
            reps = $urandom_range(3);
            len  = frame_ticks(reps);
            if (pick < 80) begin
                cut = ($urandom_range(9) == 0) ? int'($urandom_range(len - 1)) : -1;
                queue_start($urandom(), REP_W'(reps));
                for (int i = 0; i < len; i++) begin
                    if (i == cut)
                        queue_start($urandom(), REP_W'($urandom_range(255)));
                    queue_ticks(1);
                end
                counted += len + 1;
            end else if (pick < 90) begin
                cut = int'($urandom_range(len - 1, 1));
                queue_start($urandom(), REP_W'(reps));
                queue_ticks(cut);
                counted += cut + 1;
            end else begin
                queue_ticks($urandom_range(5, 1));
            end
            if ($urandom_range(5) == 0)
                wait_drained();
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers the next pending item on the falling edge, and holds it
    // until the monitor has seen it accepted. The receiver's ready is drawn
    // afresh on every falling edge.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_items
        t_item it;
        if (i_rst_n && !item_on_bus) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                it = pending_items.pop_front();
                in_ch.kind         <= it.kind;
                in_ch.code         <= it.code;
                in_ch.repeat_count <= it.repeat_count;
                in_ch.valid        <= 1'b1;
                item_on_bus = 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
        out_ch.ready <= i_rst_n && ($urandom_range(99) >= recv_gap_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: on each rising edge it checks an accepted result item against
    // the oldest prediction, then predicts for an accepted input item. The
    // result of an item never leaves in the cycle that takes the item, so
    // checking before predicting keeps the order right. It also runs the
    // watchdog on cycles in which nothing moves.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_channels
        t_item   seen;
        t_result want;
        logic    moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                moved = 1'b1;
                if (expected_pins.size() == 0) begin
                    $error("result item arrived with no prediction waiting");
                    fault_count++;
                end else begin
                    want = expected_pins.pop_front();
                    if (out_ch.pin_level !== want.pin_level) begin
                        $error("pin_level: expected %0b, got %0b",
                               want.pin_level, out_ch.pin_level);
                        fault_count++;
                    end
                    if (out_ch.busy_res !== want.busy_res) begin
                        $error("busy_res: expected %0b, got %0b",
                               want.busy_res, out_ch.busy_res);
                        fault_count++;
                    end
                    if (out_ch.done_res !== want.done_res) begin
                        $error("done_res: expected %0b, got %0b",
                               want.done_res, out_ch.done_res);
                        fault_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                moved             = 1'b1;
                seen.kind         = in_ch.kind;
                seen.code         = in_ch.code;
                seen.repeat_count = in_ch.repeat_count;
                expected_pins.push_back(advance_frame(seen));
                item_on_bus = 1'b0;
            end
            if (moved) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("rf_remote_frame_transmitter_top_test: errors");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin : run_sequence
        in_ch.valid        = 1'b0;
        in_ch.kind         = KIND_TICK;
        in_ch.code         = '0;
        in_ch.repeat_count = '0;
        out_ch.ready       = 1'b0;

        // Synchronous reset held at the start, then released on a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Opening part: the sender idles in about a third of cycles and the
        // receiver in half of them. The shortest durations keep frames brief.
        send_gap_pct = 35;
        recv_gap_pct = 50;
        set_durations(16'd1, 16'd1, 16'd1);

        // Ticks on an idle block change nothing.
        queue_ticks(2);
        // All-ones code with one repeat; the second start arrives while the
        // frame runs and must be ignored.
        queue_start(32'hFFFF_FFFF, 8'd1);
        queue_start(32'h0000_0000, 8'd255);
        queue_ticks(frame_ticks(1));
        queue_ticks(1);
        // All-zeros code with no repeats goes straight to the closing pair.
        queue_start(32'h0000_0000, 8'd0);
        queue_ticks(frame_ticks(0));
        // One repeat, with both end bits of the code set.
        queue_start(32'h8000_0001, 8'd1);
        queue_ticks(frame_ticks(1));
        close_phase();

        random_frames(110);
        close_phase();

        // Second part: idling swapped over, and zero written to every
        // duration register, each of which then lasts a single tick.
        send_gap_pct = 50;
        recv_gap_pct = 35;
        set_durations(16'd0, 16'd0, 16'd0);
        random_frames(110);
        close_phase();

        // Last part: no idling on either side.
        send_gap_pct = 0;
        recv_gap_pct = 0;
        set_durations(16'd1, 16'd5, 16'd9);
        random_frames(100);
        close_phase();

        repeat (8) @(posedge i_clk);
        if (expected_pins.size() != 0) begin
            $error("%0d result items never arrived", expected_pins.size());
            fault_count++;
        end
        if (fault_count == 0)
            $display("rf_remote_frame_transmitter_top_test: clean");
        else
            $display("rf_remote_frame_transmitter_top_test: errors");
        $finish;
    end

endmodule
